[hw/rtl/pwm_frequency_to_timer_settings_assert.svh]
// Assertion macros used by the checker file of the PWM timer settings block.
// Needs nothing else; each macro expands to one labelled concurrent assertion.
`ifndef PWM_FREQUENCY_TO_TIMER_SETTINGS_ASSERT_SVH
`define PWM_FREQUENCY_TO_TIMER_SETTINGS_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PFTT_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pftt assertion failed");

// antecedent implies consequent in the next cycle
`define PFTT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pftt assertion failed");

`endif

[hw/rtl/pftt_pkg.sv]
// Shared types and constants for the PWM timer settings block.
// Used by every RTL module of the block; depends on nothing.
`default_nettype none
package pftt_pkg;

  localparam int COUNTER_BITS = 16;
  localparam int FIELD_W      = 16;
  localparam int PSC_W        = 16;
  localparam int DIV_W        = 64;
  localparam int DIV_CNT_W    = $clog2(DIV_W);
  localparam int DIVP_W       = 48;
  localparam int Q_W          = 33;
  localparam int PROD_W       = COUNTER_BITS + 8;
  localparam int PADDR_W      = 3;

  // reciprocal of 100 for the compare quotient; exact for every product below 2^PROD_W
  localparam int RCP_SHIFT    = PROD_W + 7;
  localparam int RCP_W        = PROD_W + 1;

  localparam logic [31:0]        CLOCK_RESET = 32'd72000000;
  localparam logic [DIV_W-1:0]   PSC_LIMIT   = DIV_W'(65536);
  localparam logic [7:0]         PCT_MAX     = 8'd100;
  localparam logic [RCP_W-1:0]   RCP_MUL     = RCP_W'(((64'd1 << RCP_SHIFT) + 64'd99) / 64'd100);
  localparam logic [Q_W-1:0]     CNT_MAX     = Q_W'((64'd1 << COUNTER_BITS) - 64'd1);
  localparam logic [PADDR_W-3:0] REG_CLOCK_HZ = '0;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_ARGS = 2'd1;
  localparam logic [1:0] STATUS_RANGE    = 2'd2;

  typedef enum logic [1:0] {
    DSEL_PSC,
    DSEL_Q
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_PSC,
    ST_MUL,
    ST_QSTART,
    ST_DIV_Q,
    ST_PER,
    ST_PROD,
    ST_CQUOT,
    ST_CMP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic     load_in;
    logic     start_div;
    div_sel_t div_sel;
    logic     latch_psc;
    logic     calc_divp;
    logic     latch_q;
    logic     calc_per;
    logic     calc_prod;
    logic     calc_cquot;
    logic     set_err_args;
    logic     set_err_range;
    logic     set_ok;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic bad_args;
    logic psc_over;
    logic q_small;
    logic div_done;
  } dp_status_t;

endpackage
`default_nettype wire

[hw/rtl/pftt_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Uses pftt_pkg for the operand width; shared by the prescaler and period divisions.
`default_nettype none
module pftt_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [pftt_pkg::DIV_W-1:0]  num,
  input  wire logic [pftt_pkg::DIV_W-1:0]  den,
  output logic      [pftt_pkg::DIV_W-1:0]  quot,
  output logic                             done
);

  logic                            busy;
  logic [pftt_pkg::DIV_CNT_W-1:0]  cnt;
  logic [pftt_pkg::DIV_W-1:0]      rem;
  logic [pftt_pkg::DIV_W-1:0]      qt;
  logic [pftt_pkg::DIV_W-1:0]      den_r;
  logic [pftt_pkg::DIV_W:0]        trial;
  logic [pftt_pkg::DIV_W:0]        diff;
  logic                            ge;

  assign trial = {rem, qt[pftt_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = ~diff[pftt_pkg::DIV_W];
  assign quot  = qt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == {pftt_pkg::DIV_CNT_W{1'b1}}) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      qt    <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? diff[pftt_pkg::DIV_W-1:0] : trial[pftt_pkg::DIV_W-1:0];
      qt  <= {qt[pftt_pkg::DIV_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pftt_dp.sv]
// Datapath: operand registers, the shared divider, multipliers and result registers.
// Driven by pftt_ctrl through pftt_pkg::cmd_t; instantiates pftt_div.
`default_nettype none
module pftt_dp (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire pftt_pkg::cmd_t           cmd,
  input  wire logic [31:0]              clock_hz,
  input  wire logic [31:0]              frequency_hz,
  input  wire logic [7:0]               duty_percent,
  output pftt_pkg::dp_status_t          stat,
  output logic [1:0]                    res_status,
  output logic [pftt_pkg::FIELD_W-1:0]  res_psc,
  output logic [pftt_pkg::FIELD_W-1:0]  res_per,
  output logic [pftt_pkg::FIELD_W-1:0]  res_cmp
);

  localparam int CB = pftt_pkg::COUNTER_BITS;
  localparam int W  = pftt_pkg::DIV_W;

  logic [31:0]                    f_r;
  logic [7:0]                     d_r;
  logic [31:0]                    c_r;
  logic [pftt_pkg::PSC_W-1:0]     psc_r;
  logic [pftt_pkg::DIVP_W-1:0]    divp_r;
  logic [pftt_pkg::Q_W-1:0]       q_r;
  logic [CB-1:0]                  per_r;
  logic [pftt_pkg::PROD_W-1:0]    prod_r;
  logic [CB:0]                    cq_r;

  logic [pftt_pkg::PSC_W:0]       psc_inc;
  logic [pftt_pkg::DIVP_W-1:0]    divp_calc;
  logic [pftt_pkg::Q_W-1:0]       q_dec;
  logic [CB:0]                    per_inc;
  logic [pftt_pkg::PROD_W-1:0]    prod_calc;
  logic [pftt_pkg::PROD_W+pftt_pkg::RCP_W-1:0] rcp_prod;
  logic [CB-1:0]                  cmp_calc;
  logic [W-1:0]                   div_num;
  logic [W-1:0]                   div_den;
  logic [W-1:0]                   quot;
  logic                           div_done;

  pftt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start_div),
    .num   (div_num),
    .den   (div_den),
    .quot  (quot),
    .done  (div_done)
  );

  // operand select for the shared divider
  always_comb begin
    case (cmd.div_sel)
      pftt_pkg::DSEL_PSC: begin
        div_num = W'(c_r);
        div_den = (W'(f_r[30:0]) << CB) + W'(f_r[30:0]);
      end
      pftt_pkg::DSEL_Q: begin
        div_num = (W'(c_r) << 1) + W'(divp_r);
        div_den = W'(divp_r) << 1;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  assign psc_inc   = {1'b0, psc_r} + 1'b1;
  assign divp_calc = psc_inc * f_r[30:0];
  assign q_dec     = q_r - 1'b1;
  assign per_inc   = {1'b0, per_r} + 1'b1;
  assign prod_calc = per_inc * d_r[6:0];
  // divide the product by 100 through its reciprocal
  assign rcp_prod  = prod_r * pftt_pkg::RCP_MUL;
  assign cmp_calc  = (cq_r > {1'b0, per_r}) ? per_r : cq_r[CB-1:0];

  assign stat.bad_args = f_r[31] | (f_r == 32'd0) | d_r[7] | (d_r > pftt_pkg::PCT_MAX);
  assign stat.psc_over = (quot >= pftt_pkg::PSC_LIMIT);
  assign stat.q_small  = (q_r <= pftt_pkg::Q_W'(1));
  assign stat.div_done = div_done;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      f_r <= frequency_hz;
      d_r <= duty_percent;
      c_r <= clock_hz;
    end
    if (cmd.latch_psc) begin
      psc_r <= quot[pftt_pkg::PSC_W-1:0];
    end
    if (cmd.calc_divp) begin
      divp_r <= divp_calc;
    end
    if (cmd.latch_q) begin
      q_r <= quot[pftt_pkg::Q_W-1:0];
    end
    if (cmd.calc_per) begin
      // saturate the rounded period at the counter maximum
      per_r <= (q_dec > pftt_pkg::CNT_MAX) ? CB'(pftt_pkg::CNT_MAX) : CB'(q_dec);
    end
    if (cmd.calc_prod) begin
      prod_r <= prod_calc;
    end
    if (cmd.calc_cquot) begin
      cq_r <= rcp_prod[pftt_pkg::RCP_SHIFT +: CB+1];
    end
    if (cmd.set_err_args || cmd.set_err_range) begin
      res_status <= cmd.set_err_args ? pftt_pkg::STATUS_BAD_ARGS : pftt_pkg::STATUS_RANGE;
      res_psc    <= '0;
      res_per    <= '0;
      res_cmp    <= '0;
    end else if (cmd.set_ok) begin
      res_status <= pftt_pkg::STATUS_OK;
      res_psc    <= pftt_pkg::FIELD_W'(psc_r);
      res_per    <= pftt_pkg::FIELD_W'(per_r);
      res_cmp    <= pftt_pkg::FIELD_W'(cmp_calc);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pftt_ctrl.sv]
// Controller state machine sequencing the checks, divisions and multiplies.
// Uses pftt_pkg types; issues cmd_t to pftt_dp and reads its dp_status_t.
`default_nettype none
module pftt_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 out_free,
  input  wire pftt_pkg::dp_status_t stat,
  output logic                      in_ready,
  output pftt_pkg::cmd_t            cmd
);

  pftt_pkg::state_t state;
  pftt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pftt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pftt_pkg::ST_IDLE:    if (in_valid) state_next = pftt_pkg::ST_CHECK;
      pftt_pkg::ST_CHECK:   state_next = stat.bad_args ? pftt_pkg::ST_FINISH
                                                       : pftt_pkg::ST_DIV_PSC;
      pftt_pkg::ST_DIV_PSC: begin
        if (stat.div_done) begin
          state_next = stat.psc_over ? pftt_pkg::ST_FINISH : pftt_pkg::ST_MUL;
        end
      end
      pftt_pkg::ST_MUL:     state_next = pftt_pkg::ST_QSTART;
      pftt_pkg::ST_QSTART:  state_next = pftt_pkg::ST_DIV_Q;
      pftt_pkg::ST_DIV_Q:   if (stat.div_done) state_next = pftt_pkg::ST_PER;
      pftt_pkg::ST_PER:     state_next = stat.q_small ? pftt_pkg::ST_FINISH
                                                      : pftt_pkg::ST_PROD;
      pftt_pkg::ST_PROD:    state_next = pftt_pkg::ST_CQUOT;
      pftt_pkg::ST_CQUOT:   state_next = pftt_pkg::ST_CMP;
      pftt_pkg::ST_CMP:     state_next = pftt_pkg::ST_FINISH;
      pftt_pkg::ST_FINISH:  if (out_free) state_next = pftt_pkg::ST_IDLE;
      default:              state_next = pftt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.div_sel = pftt_pkg::DSEL_PSC;
    in_ready = 1'b0;
    case (state)
      pftt_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      pftt_pkg::ST_CHECK: begin
        cmd.set_err_args = stat.bad_args;
        cmd.start_div    = ~stat.bad_args;
        cmd.div_sel      = pftt_pkg::DSEL_PSC;
      end
      pftt_pkg::ST_DIV_PSC: begin
        cmd.latch_psc     = stat.div_done & ~stat.psc_over;
        cmd.set_err_range = stat.div_done & stat.psc_over;
      end
      pftt_pkg::ST_MUL: begin
        cmd.calc_divp = 1'b1;
      end
      pftt_pkg::ST_QSTART: begin
        cmd.start_div = 1'b1;
        cmd.div_sel   = pftt_pkg::DSEL_Q;
      end
      pftt_pkg::ST_DIV_Q: begin
        cmd.latch_q = stat.div_done;
      end
      pftt_pkg::ST_PER: begin
        cmd.set_err_range = stat.q_small;
        cmd.calc_per      = ~stat.q_small;
      end
      pftt_pkg::ST_PROD: begin
        cmd.calc_prod = 1'b1;
      end
      pftt_pkg::ST_CQUOT: begin
        cmd.calc_cquot = 1'b1;
      end
      pftt_pkg::ST_CMP: begin
        cmd.set_ok = 1'b1;
      end
      pftt_pkg::ST_FINISH: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/pwm_frequency_to_timer_settings.sv]
// A good request makes two passes of the 64-step shared divider before its result is
// valid; an erroneous request finishes with fewer steps.
// One item is handled at a time, and the next item is taken while the previous
// result still waits in the output register.
// Reset (synchronous, active high): clock_hz returns to 72000000, controller idles,
// output stage empties.
`default_nettype none
module pwm_frequency_to_timer_settings (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // APB-style configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pftt_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  // request stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [39:0]                   s_tdata,  // frequency_hz[31:0], duty_percent[39:32]
  // result stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [47:0]                   m_tdata,  // prescaler[15:0], period[31:16], compare[47:32]
  output logic      [1:0]                    m_tuser   // status[1:0]
);

  logic [31:0]                    clock_hz;
  logic                           reg_hit;
  logic                           out_free;
  pftt_pkg::cmd_t                 cmd;
  pftt_pkg::dp_status_t           stat;
  logic [1:0]                     res_status;
  logic [pftt_pkg::FIELD_W-1:0]   res_psc;
  logic [pftt_pkg::FIELD_W-1:0]   res_per;
  logic [pftt_pkg::FIELD_W-1:0]   res_cmp;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[pftt_pkg::PADDR_W-1:2] == pftt_pkg::REG_CLOCK_HZ);
  assign prdata  = reg_hit ? clock_hz : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= pftt_pkg::CLOCK_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      clock_hz <= pwdata;
    end
  end

  assign out_free = ~m_tvalid | m_tready;

  pftt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .out_free (out_free),
    .stat     (stat),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  pftt_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .clock_hz     (clock_hz),
    .frequency_hz (s_tdata[31:0]),
    .duty_percent (s_tdata[39:32]),
    .stat         (stat),
    .res_status   (res_status),
    .res_psc      (res_psc),
    .res_per      (res_per),
    .res_cmp      (res_cmp)
  );

  // output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {res_cmp, res_per, res_psc};
      m_tuser <= res_status;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pftt_checker.sv]
// Port-level checker for the PWM timer settings block, bound to the top level.
// Takes the assertion macros from pwm_frequency_to_timer_settings_assert.svh.
`default_nettype none
`include "pwm_frequency_to_timer_settings_assert.svh"
module pftt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  logic ok_item;
  logic err_item;

  assign ok_item  = m_tvalid && (m_tuser == pftt_pkg::STATUS_OK);
  assign err_item = m_tvalid && (m_tuser != pftt_pkg::STATUS_OK);

  `PFTT_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable({m_tuser, m_tdata}))
  `PFTT_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)
  `PFTT_ASSERT_SAME(a_status_code, clk, rst, m_tvalid, m_tuser <= pftt_pkg::STATUS_RANGE)
  `PFTT_ASSERT_SAME(a_error_zeroed, clk, rst, err_item, m_tdata == 48'd0)
  `PFTT_ASSERT_SAME(a_cmp_le_per, clk, rst, ok_item, m_tdata[47:32] <= m_tdata[31:16])

endmodule

bind pwm_frequency_to_timer_settings pftt_checker u_pftt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

[verif/tb_pwm_frequency_to_timer_settings.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the PWM timer settings block: streams frequency and
// duty requests, predicts prescaler, period and compare, and checks every result.
// Depends on pftt_pkg and the block's top module only.
module tb_pwm_frequency_to_timer_settings;
  import pftt_pkg::*;

  localparam int          CLK_HALF      = 5;
  localparam int          RESET_CYCLES  = 8;
  localparam int          ITEMS_PER_SET = 300;
  localparam int          HOLD_CYCLES   = 2000;
  localparam int          HOLD_SPACING  = 800;
  localparam int          DRAIN_CYCLES  = 300;
  localparam longint      CYCLE_LIMIT   = 4000000;
  localparam int          DUTY_MAX      = 100;
  localparam logic [63:0] PSC_CEILING   = 64'd65536;
  localparam logic [31:0] FREQ_MASK     = 32'h7FFF_FFFF;
  localparam logic [31:0] SIGN_BIT      = 32'h8000_0000;

  typedef struct {
    logic signed [31:0] freq;
    logic signed [7:0]  duty;
  } pwm_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] psc;
    logic [15:0] per;
    logic [15:0] cmp;
  } timer_set_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [39:0]        s_tdata = '0;  // frequency_hz[31:0], duty_percent[39:32]
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [47:0]        m_tdata;       // prescaler[15:0], period[31:16], compare[47:32]
  logic [1:0]         m_tuser;       // status[1:0]

  pwm_req_t    pending_requests[$];
  timer_set_t  expected_settings[$];
  logic [31:0] clock_hz_model = CLOCK_RESET;
  int          mismatches = 0;
  int          results_seen = 0;
  int unsigned hold_left = 0;
  int          next_hold_at = 40;
  bit          quiet = 1'b0;
  longint      cycle_count = 0;

  pwm_frequency_to_timer_settings dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #CLK_HALF clk = ~clk;

  function automatic timer_set_t settings_for(input logic [31:0] clk_hz, input pwm_req_t r);
    logic [63:0] f, c, top, psc, div, q, per, cmp;
    timer_set_t  s;
    s.status = STATUS_OK;
    s.psc    = '0;
    s.per    = '0;
    s.cmp    = '0;
    top = (64'd1 << COUNTER_BITS) - 64'd1;
    if (r.freq <= 0 || r.duty < 0 || r.duty > DUTY_MAX) begin
      s.status = STATUS_BAD_ARGS;
      return s;
    end
    f   = {32'd0, r.freq};
    c   = {32'd0, clk_hz};
    psc = c / ((top + 64'd2) * f);
    if (psc >= PSC_CEILING) begin
      s.status = STATUS_RANGE;
      return s;
    end
    div = (psc + 64'd1) * f;
    // round half up
    q = (64'd2 * c + div) / (64'd2 * div);
    if (q <= 64'd1) begin
      s.status = STATUS_RANGE;
      return s;
    end
    per = q - 64'd1;
    if (per > top) per = top;
    cmp = ((per + 64'd1) * {56'd0, r.duty}) / 64'd100;
    if (cmp > per) cmp = per;
    s.psc = psc[15:0];
    s.per = per[15:0];
    s.cmp = cmp[15:0];
    return s;
  endfunction

  function automatic int unsigned idle_length(input bit no_gaps);
    int unsigned roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic pwm_req_t make_request(input logic [31:0] f, input logic [7:0] d);
    pwm_req_t r;
    r.freq = f;
    r.duty = d;
    return r;
  endfunction

  function automatic pwm_req_t random_request(input logic [31:0] clk_hz);
    pwm_req_t    r;
    int unsigned roll, k;
    logic [31:0] f;
    roll   = $urandom_range(0, 99);
    r.duty = 8'($urandom_range(0, DUTY_MAX));
    if ($urandom_range(0, 9) == 0) r.duty = ($urandom_range(0, 1) != 0) ? 8'd0 : 8'd100;
    if (roll < 4) begin
      r.freq = $urandom | SIGN_BIT;
    end else if (roll < 6) begin
      r.freq = '0;
    end else if (roll < 9) begin
      r.freq = 32'($urandom_range(1, 1000000));
      r.duty = 8'($urandom_range(128, 255));
    end else if (roll < 12) begin
      r.freq = 32'($urandom_range(1, 1000000));
      r.duty = 8'($urandom_range(DUTY_MAX + 1, 127));
    end else if (roll < 40) begin
      // aim near the clock so that small periods and the range limit come up
      f = clk_hz / $urandom_range(1, 200000);
      f = (f + $urandom_range(0, 3)) & FREQ_MASK;
      r.freq = (f == 0) ? 32'd1 : f;
    end else begin
      k = $urandom_range(0, 30);
      r.freq = 32'($urandom_range(32'd1 << k, (32'd1 << (k + 1)) - 32'd1));
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input longint got, input longint want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  task automatic write_clock_hz(input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CLOCK_HZ, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    clock_hz_model = value;
  endtask

  task automatic check_clock_hz();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_CLOCK_HZ, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== clock_hz_model) note_mismatch("clock_hz readback", prdata, clock_hz_model);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_until_drained();
    while (pending_requests.size() != 0 || s_tvalid || expected_settings.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin : request_driver
    pwm_req_t    offered;
    int unsigned gap;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_settings.push_back(settings_for(clock_hz_model, offered));
        if ($urandom_range(0, 63) == 0) quiet <= !quiet;
      end
      if (s_tvalid && !s_tready) begin
        // hold the item until taken
      end else if (gap != 0) begin
        gap = gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        offered = pending_requests.pop_front();
        s_tdata  <= {offered.duty, offered.freq};
        s_tvalid <= 1'b1;
        gap = idle_length(quiet);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    timer_set_t  want;
    int unsigned stall_left;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (expected_settings.size() == 0) begin
          note_mismatch("result with nothing expected, status", m_tuser, 0);
        end else begin
          want = expected_settings.pop_front();
          if (m_tuser !== want.status) note_mismatch("status", m_tuser, want.status);
          if (m_tdata[15:0] !== want.psc) note_mismatch("prescaler", m_tdata[15:0], want.psc);
          if (m_tdata[31:16] !== want.per) note_mismatch("period", m_tdata[31:16], want.per);
          if (m_tdata[47:32] !== want.cmp) note_mismatch("compare", m_tdata[47:32], want.cmp);
        end
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
      end else if (stall_left != 0) begin
        m_tready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 15) == 0) stall_left = idle_length(quiet);
      end
    end
  end

  // long hold-off on the result side so that the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (results_seen >= next_hold_at) begin
      hold_left    <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + HOLD_SPACING;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] set_clock[6];
    set_clock[0] = 32'hFFFF_FFFF;
    set_clock[1] = 32'd1;
    set_clock[2] = CLOCK_RESET;
    set_clock[3] = 32'($urandom_range(1000, 100000000));
    set_clock[4] = 32'($urandom_range(1, 32'hFFFF_FFFF));
    set_clock[5] = 32'($urandom_range(2, 65536));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    check_clock_hz();

    // directed requests at the reset clock
    pending_requests.push_back(make_request(32'd1, 8'd0));
    pending_requests.push_back(make_request(32'd1, 8'd100));
    pending_requests.push_back(make_request(32'd1000, 8'd50));
    pending_requests.push_back(make_request(32'd20000, 8'd25));
    pending_requests.push_back(make_request(32'd36000000, 8'd50));
    pending_requests.push_back(make_request(32'd48000000, 8'd50));
    pending_requests.push_back(make_request(32'd72000000, 8'd50));
    pending_requests.push_back(make_request(FREQ_MASK, 8'd50));
    pending_requests.push_back(make_request(32'd0, 8'd50));
    pending_requests.push_back(make_request(32'hFFFF_FFFF, 8'd50));
    pending_requests.push_back(make_request(SIGN_BIT, 8'd50));
    pending_requests.push_back(make_request(32'd1000, 8'hFF));
    pending_requests.push_back(make_request(32'd1000, 8'h80));
    pending_requests.push_back(make_request(32'd1000, 8'd101));
    pending_requests.push_back(make_request(32'd1000, 8'd127));
    pending_requests.push_back(make_request(32'd1000, 8'd100));
    wait_until_drained();

    // rounded period one past the counter top saturates, compare capped
    write_clock_hz(32'd131073);
    check_clock_hz();
    pending_requests.push_back(make_request(32'd2, 8'd100));
    pending_requests.push_back(make_request(32'd2, 8'd50));
    pending_requests.push_back(make_request(32'd1, 8'd0));
    pending_requests.push_back(make_request(32'd65537, 8'd99));
    wait_until_drained();

    foreach (set_clock[i]) begin
      write_clock_hz(set_clock[i]);
      check_clock_hz();
      repeat (ITEMS_PER_SET) pending_requests.push_back(random_request(clock_hz_model));
      wait_until_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_settings.size() != 0)
      note_mismatch("results never delivered", 0, expected_settings.size());
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/pftt_pkg.sv
hw/rtl/pftt_div.sv
hw/rtl/pftt_dp.sv
hw/rtl/pftt_ctrl.sv
hw/rtl/pwm_frequency_to_timer_settings.sv
hw/rtl/pftt_checker.sv
verif/tb_pwm_frequency_to_timer_settings.sv
